// ===== hw/rtl/pfe_pkg.sv =====
// Playfair encipherer shared package: constants, codes, state enum,
// memory request/response structs and cell arithmetic helpers.
// No dependencies.
package pfe_pkg;

  localparam logic [4:0]  CELLS       = 5'd25;
  localparam logic [4:0]  LAST_LETTER = 5'd25;
  localparam logic [4:0]  LETTER_Q    = 5'd16;
  localparam logic [4:0]  LETTER_X    = 5'd23;
  localparam logic [25:0] USED_RESET  = 26'h001_0000;
  localparam logic [6:0]  ASCII_A     = 7'd65;
  localparam logic [7:0]  LOWER_A     = 8'h61;
  localparam logic [7:0]  LOWER_Z     = 8'h7a;

  typedef enum logic [2:0] {
    OP_KEY_START = 3'd0,
    OP_KEY_BYTE  = 3'd1,
    OP_KEY_END   = 3'd2,
    OP_TEXT_BYTE = 3'd3,
    OP_TEXT_END  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_EOL    = 2'd1,
    KIND_ERR    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_CELL,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_EMIT_EOL,
    ST_EMIT_ERR
  } state_e;

  typedef struct packed {
    logic       wr_en;
    logic [4:0] wr_cell;
    logic [4:0] wr_letter;
    logic       col_rd_en;
    logic [4:0] col_rd_a;
    logic [4:0] col_rd_b;
    logic       sq_rd_en;
    logic [4:0] sq_rd_a;
    logic [4:0] sq_rd_b;
  } pfe_mem_req_t;

  typedef struct packed {
    logic [4:0] col_a;
    logic [4:0] col_b;
    logic [4:0] sq_a;
    logic [4:0] sq_b;
  } pfe_mem_rsp_t;

  function automatic logic [2:0] cell_row(input logic [4:0] c);
    logic [2:0] r;
    if (c >= 5'd20)      r = 3'd4;
    else if (c >= 5'd15) r = 3'd3;
    else if (c >= 5'd10) r = 3'd2;
    else if (c >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] c);
    logic [4:0] base;
    logic [4:0] diff;
    base = {2'b00, cell_row(c)} * 5'd5;
    diff = c - base;
    return diff[2:0];
  endfunction

  function automatic logic [4:0] make_cell(input logic [2:0] r, input logic [2:0] k);
    return {2'b00, r} * 5'd5 + {2'b00, k};
  endfunction

  function automatic logic [2:0] inc5(input logic [2:0] x);
    return (x == 3'd4) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

// ===== hw/rtl/pfe_intf.sv =====
// Item channel interfaces of the Playfair encipherer: input and result.
// Valid/ready handshake; no dependencies.
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] character;

  modport source (output valid, output operation, output character, input ready);
  modport sink   (input valid, input operation, input character, output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] letter;
  logic       last;

  modport source (output valid, output kind, output letter, output last, input ready);
  modport sink   (input valid, input kind, input letter, input last, output ready);
endinterface

// ===== hw/rtl/pfe_store.sv =====
// Square and letter-to-cell memories, one write and two registered reads each.
// Per-entry valid bits give the all-zero reset contents. Uses pfe_pkg.
module pfe_store import pfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pfe_mem_req_t req_i,
  output pfe_mem_rsp_t rsp_o
);

  logic [4:0]  sq_mem  [25];
  logic [4:0]  col_mem [26];
  logic [24:0] sq_vld_q;
  logic [25:0] col_vld_q;

  logic [4:0] col_a_q, col_b_q, sq_a_q, sq_b_q;
  logic       col_a_v_q, col_b_v_q, sq_a_v_q, sq_b_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= '0;
      col_vld_q <= '0;
    end else if (req_i.wr_en) begin
      sq_vld_q[req_i.wr_cell]    <= 1'b1;
      col_vld_q[req_i.wr_letter] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      sq_mem[req_i.wr_cell]    <= req_i.wr_letter;
      col_mem[req_i.wr_letter] <= req_i.wr_cell;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.col_rd_en) begin
      col_a_q   <= col_mem[req_i.col_rd_a];
      col_b_q   <= col_mem[req_i.col_rd_b];
      col_a_v_q <= col_vld_q[req_i.col_rd_a];
      col_b_v_q <= col_vld_q[req_i.col_rd_b];
    end
    if (req_i.sq_rd_en) begin
      sq_a_q   <= sq_mem[req_i.sq_rd_a];
      sq_b_q   <= sq_mem[req_i.sq_rd_b];
      sq_a_v_q <= sq_vld_q[req_i.sq_rd_a];
      sq_b_v_q <= sq_vld_q[req_i.sq_rd_b];
    end
  end

  assign rsp_o.col_a = col_a_v_q ? col_a_q : 5'd0;
  assign rsp_o.col_b = col_b_v_q ? col_b_q : 5'd0;
  assign rsp_o.sq_a  = sq_a_v_q  ? sq_a_q  : 5'd0;
  assign rsp_o.sq_b  = sq_b_v_q  ? sq_b_q  : 5'd0;

endmodule

// ===== hw/rtl/pfe_ctrl.sv =====
// Sequencer of the Playfair encipherer: key placement, alphabet fill walk,
// pair lookup and the result register. Uses pfe_pkg, pfe_intf.
module pfe_ctrl import pfe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfe_in_if.sink        in_i,
  pfe_out_if.source     out_o,
  output pfe_mem_req_t  req_o,
  input  pfe_mem_rsp_t  rsp_i
);

  state_e      state_q, state_d;
  logic [25:0] used_q, used_d;
  logic [4:0]  fill_q, fill_d;
  logic [4:0]  pend_q, pend_d;
  logic        pend_v_q, pend_v_d;
  logic [4:0]  t_q, t_d;
  logic        end_q, end_d;

  logic        out_v_q, out_v_d;
  kind_e       kind_q;
  logic [6:0]  letter_q;
  logic        last_q;

  logic        load;
  kind_e       ld_kind;
  logic [6:0]  ld_letter;
  logic        ld_last;
  logic        out_free;

  logic        place_en;
  logic [4:0]  place_letter;

  logic [7:0]  ch_off;
  logic        in_lower;
  logic [4:0]  in_letter;

  logic [2:0]  r1, k1, r2, k2;

  assign ch_off    = in_i.character - LOWER_A;
  assign in_lower  = (in_i.character >= LOWER_A) && (in_i.character <= LOWER_Z);
  assign in_letter = ch_off[4:0];
  assign out_free  = !out_v_q || out_o.ready;

  assign r1 = cell_row(rsp_i.col_a);
  assign k1 = cell_col(rsp_i.col_a);
  assign r2 = cell_row(rsp_i.col_b);
  assign k2 = cell_col(rsp_i.col_b);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    fill_d       = fill_q;
    pend_d       = pend_q;
    pend_v_d     = pend_v_q;
    t_d          = t_q;
    end_d        = end_q;
    req_o        = '0;
    place_en     = 1'b0;
    place_letter = in_letter;
    load         = 1'b0;
    ld_kind      = KIND_LETTER;
    ld_letter    = 7'd0;
    ld_last      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (op_e'(in_i.operation))
            OP_KEY_START: begin
              used_d   = USED_RESET;
              fill_d   = 5'd0;
              pend_v_d = 1'b0;
            end
            OP_KEY_BYTE: begin
              place_en = in_lower && !used_q[in_letter] && (fill_q < CELLS);
            end
            OP_KEY_END: begin
              t_d      = 5'd0;
              pend_v_d = 1'b0;
              state_d  = ST_FILL;
            end
            OP_TEXT_BYTE: begin
              if (in_lower) begin
                if (in_letter == LETTER_Q) begin
                  state_d = ST_EMIT_ERR;
                end else if (!pend_v_q) begin
                  pend_d   = in_letter;
                  pend_v_d = 1'b1;
                end else begin
                  req_o.col_rd_en = 1'b1;
                  req_o.col_rd_a  = pend_q;
                  if (in_letter == pend_q) begin
                    req_o.col_rd_b = LETTER_X;
                  end else begin
                    req_o.col_rd_b = in_letter;
                    pend_v_d       = 1'b0;
                  end
                  end_d   = 1'b0;
                  state_d = ST_CELL;
                end
              end
            end
            OP_TEXT_END: begin
              pend_v_d = 1'b0;
              if (pend_v_q) begin
                req_o.col_rd_en = 1'b1;
                req_o.col_rd_a  = pend_q;
                req_o.col_rd_b  = LETTER_X;
                end_d           = 1'b1;
                state_d         = ST_CELL;
              end else begin
                state_d = ST_EMIT_EOL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_letter = t_q;
        place_en     = !used_q[t_q] && (fill_q < CELLS);
        t_d          = t_q + 5'd1;
        if (t_q == LAST_LETTER) state_d = ST_IDLE;
      end
      ST_CELL: begin
        req_o.sq_rd_en = 1'b1;
        if (r1 == r2) begin
          req_o.sq_rd_a = make_cell(r1, inc5(k1));
          req_o.sq_rd_b = make_cell(r2, inc5(k2));
        end else if (k1 == k2) begin
          req_o.sq_rd_a = make_cell(inc5(r1), k1);
          req_o.sq_rd_b = make_cell(inc5(r2), k2);
        end else begin
          req_o.sq_rd_a = make_cell(r1, k2);
          req_o.sq_rd_b = make_cell(r2, k1);
        end
        state_d = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (out_free) begin
          load      = 1'b1;
          ld_letter = ASCII_A + {2'b00, rsp_i.sq_a};
          state_d   = ST_EMIT_B;
        end
      end
      ST_EMIT_B: begin
        if (out_free) begin
          load      = 1'b1;
          ld_letter = ASCII_A + {2'b00, rsp_i.sq_b};
          ld_last   = !end_q;
          state_d   = end_q ? ST_EMIT_EOL : ST_IDLE;
        end
      end
      ST_EMIT_EOL: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_EOL;
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_ERR: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_ERR;
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (place_en) begin
      req_o.wr_en            = 1'b1;
      req_o.wr_cell          = fill_q;
      req_o.wr_letter        = place_letter;
      used_d[place_letter]   = 1'b1;
      fill_d                 = fill_q + 5'd1;
    end
  end

  always_comb begin
    if (load)             out_v_d = 1'b1;
    else if (out_o.ready) out_v_d = 1'b0;
    else                  out_v_d = out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= USED_RESET;
      fill_q   <= 5'd0;
      pend_q   <= 5'd0;
      pend_v_q <= 1'b0;
      t_q      <= 5'd0;
      end_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      fill_q   <= fill_d;
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
      t_q      <= t_d;
      end_q    <= end_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= ld_kind;
      letter_q <= ld_letter;
      last_q   <= ld_last;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.kind   = kind_q;
  assign out_o.letter = (kind_q == KIND_LETTER) ? letter_q : 7'd0;
  assign out_o.last   = last_q;

endmodule

// ===== hw/rtl/playfair_encipher_top.sv =====
// Playfair encipherer top level: sequencer plus square/cell memories.
// Uses pfe_pkg, pfe_intf, pfe_store, pfe_ctrl.
//
// One item is taken at a time. Key start, key bytes, ignored bytes and the
// first letter of a pair are done in their accept cycle. For a completed pair
// the accept cycle reads the cell of both letters, the next reads the two
// ciphertext cells of the square, and the emit states hand out the letters;
// text end with an open pair adds a state for the line-end marker. Key end
// is the accept followed by the fill walk over every alphabet letter. A
// plaintext q and a bare text end are the accept followed by an emit state.
// The result register lets the next item be taken while the last result
// still waits; a stalled result side holds the sequencer in its emit states.
module playfair_encipher_top import pfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfe_in_if.sink     in_i,
  pfe_out_if.source  out_o
);

  pfe_mem_req_t mem_req;
  pfe_mem_rsp_t mem_rsp;

  pfe_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  pfe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .req_o  (mem_req),
    .rsp_i  (mem_rsp)
  );

  a_wr_in_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (mem_req.wr_cell < CELLS) && (mem_req.wr_letter <= LAST_LETTER))
    else $error("square write out of range");

  a_lookup_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.col_rd_en |=> mem_req.sq_rd_en && !in_i.ready)
    else $error("cell lookup not followed by square read");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_LETTER) |->
      (out_o.letter >= 7'd65) && (out_o.letter <= 7'd90))
    else $error("ciphertext letter out of range");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind != KIND_LETTER) |-> out_o.last)
    else $error("marker or error result not last");

endmodule
